>>> rtl/rgb565_palette_quantize_to_bitplanes_assert.svh
// Assertion macros for the palette quantizer.
`ifndef RGB565_PALETTE_QUANTIZE_TO_BITPLANES_ASSERT_SVH
`define RGB565_PALETTE_QUANTIZE_TO_BITPLANES_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RPQB_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RPQB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/rpqb_pkg.sv
// Package: word types, constants and the color distance function of the palette quantizer.
package rpqb_pkg;

    localparam int STORE_DEPTH         = 32;
    localparam int DEF_PALETTE_ENTRIES = 32;
    localparam int IDX_W               = 5;
    localparam int GROUP_PIXELS        = 8;
    localparam int NUM_PLANES          = 5;
    localparam int DIST_W              = 11;
    localparam logic [DIST_W-1:0] DIST_NONE = '1;

    localparam logic FUNC_PAL_WRITE = 1'b0;
    localparam logic FUNC_CONVERT   = 1'b1;

    typedef struct packed {
        logic        func;
        logic [4:0]  pal_index;
        logic [11:0] pal_color;
        logic [15:0] pixel0;
        logic [15:0] pixel1;
        logic [15:0] pixel2;
        logic [15:0] pixel3;
        logic [15:0] pixel4;
        logic [15:0] pixel5;
        logic [15:0] pixel6;
        logic [15:0] pixel7;
    } in_word_t;

    typedef struct packed {
        logic [7:0] plane0;
        logic [7:0] plane1;
        logic [7:0] plane2;
        logic [7:0] plane3;
        logic [7:0] plane4;
    } out_word_t;

    function automatic logic [7:0] sq_diff(input logic [3:0] a, input logic [3:0] b);
        logic [3:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return {4'b0000, d} * {4'b0000, d};
    endfunction

    function automatic logic [DIST_W-1:0] color_dist(input logic [15:0] pix,
                                                     input logic [11:0] col);
        logic [7:0] sr;
        logic [7:0] sg;
        logic [7:0] sb;
        sr = sq_diff(pix[15:12], col[11:8]);
        sg = sq_diff(pix[10:7], col[7:4]);
        sb = sq_diff(pix[4:1], col[3:0]);
        return DIST_W'({sr, 1'b0}) + DIST_W'({sg, 2'b00}) + DIST_W'({sb, 1'b0})
             + DIST_W'(sb);
    endfunction

endpackage

>>> rtl/rgb565_palette_quantize_to_bitplanes.sv
// Top level: RGB565 to palette index quantizer with bitplane packing.
// channel | ports                     | word
// input   | s_valid s_ready s_data    | in_word_t: palette write or eight-pixel group
// result  | m_valid m_ready m_data    | out_word_t: five bitplane bytes
// The pixels of a group word enter the distance stage one per cycle while the pipeline advances.
// A palette write only updates the palette; each pixel passes a 32-lane distance stage
// and a registered min tree (s2, s3) before its index reaches the result register.
// Reset clears the palette to zero and empties the pipeline.
// The pipeline stalls only when a finished word meets a full, untaken result register.
`include "rgb565_palette_quantize_to_bitplanes_assert.svh"

module rgb565_palette_quantize_to_bitplanes
    import rpqb_pkg::*;
#(
    parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam int CNT_W = $clog2(GROUP_PIXELS + 1);
    localparam int S2_N  = STORE_DEPTH / 4;
    localparam int S3_N  = STORE_DEPTH / 16;

    logic [11:0]       palette_reg [PALETTE_ENTRIES];
    logic [15:0]       pix_sh_reg  [GROUP_PIXELS];
    logic [CNT_W-1:0]  cnt_reg;

    logic              s1_valid_reg, s1_last_reg;
    logic [DIST_W-1:0] s1_dist_reg [STORE_DEPTH];
    logic              s2_valid_reg, s2_last_reg;
    logic [DIST_W-1:0] s2_dist_reg [S2_N];
    logic [IDX_W-1:0]  s2_idx_reg  [S2_N];
    logic              s3_valid_reg, s3_last_reg;
    logic [DIST_W-1:0] s3_dist_reg [S3_N];
    logic [IDX_W-1:0]  s3_idx_reg  [S3_N];

    logic [7:0]        acc_reg  [NUM_PLANES];
    logic [7:0]        acc_next [NUM_PLANES];
    logic              m_valid_reg, m_valid_next;
    out_word_t         m_data_reg;

    logic [DIST_W-1:0] lane_dist [STORE_DEPTH];
    logic [DIST_W-1:0] s2_dist_next [S2_N];
    logic [IDX_W-1:0]  s2_idx_next  [S2_N];
    logic [DIST_W-1:0] s3_dist_next [S3_N];
    logic [IDX_W-1:0]  s3_idx_next  [S3_N];
    logic [IDX_W-1:0]  fin_idx;

    logic pipe_adv, s_accept, issue;

    assign pipe_adv = !(m_valid_reg && !m_ready && s3_valid_reg && s3_last_reg);
    assign s_ready  = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && pipe_adv);
    assign s_accept = s_valid && s_ready;
    assign issue    = cnt_reg != '0;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    genvar gi;
    generate
        for (gi = 0; gi < STORE_DEPTH; gi++) begin : g_lane
            if (gi < PALETTE_ENTRIES) begin : g_used
                assign lane_dist[gi] = color_dist(pix_sh_reg[0], palette_reg[gi]);
            end else begin : g_pad
                assign lane_dist[gi] = DIST_NONE;
            end
        end
    endgenerate

    always_comb begin
        logic [DIST_W-1:0] l1_d [STORE_DEPTH/2];
        logic [IDX_W-1:0]  l1_i [STORE_DEPTH/2];
        logic [DIST_W-1:0] l3_d [S2_N/2];
        logic [IDX_W-1:0]  l3_i [S2_N/2];
        for (int j = 0; j < STORE_DEPTH / 2; j++) begin
            if (s1_dist_reg[2*j+1] < s1_dist_reg[2*j]) begin
                l1_d[j] = s1_dist_reg[2*j+1];
                l1_i[j] = IDX_W'(2*j+1);
            end else begin
                l1_d[j] = s1_dist_reg[2*j];
                l1_i[j] = IDX_W'(2*j);
            end
        end
        for (int j = 0; j < S2_N; j++) begin
            if (l1_d[2*j+1] < l1_d[2*j]) begin
                s2_dist_next[j] = l1_d[2*j+1];
                s2_idx_next[j]  = l1_i[2*j+1];
            end else begin
                s2_dist_next[j] = l1_d[2*j];
                s2_idx_next[j]  = l1_i[2*j];
            end
        end
        for (int j = 0; j < S2_N / 2; j++) begin
            if (s2_dist_reg[2*j+1] < s2_dist_reg[2*j]) begin
                l3_d[j] = s2_dist_reg[2*j+1];
                l3_i[j] = s2_idx_reg[2*j+1];
            end else begin
                l3_d[j] = s2_dist_reg[2*j];
                l3_i[j] = s2_idx_reg[2*j];
            end
        end
        for (int j = 0; j < S3_N; j++) begin
            if (l3_d[2*j+1] < l3_d[2*j]) begin
                s3_dist_next[j] = l3_d[2*j+1];
                s3_idx_next[j]  = l3_i[2*j+1];
            end else begin
                s3_dist_next[j] = l3_d[2*j];
                s3_idx_next[j]  = l3_i[2*j];
            end
        end
    end

    always_comb begin
        fin_idx = (s3_dist_reg[1] < s3_dist_reg[0]) ? s3_idx_reg[1] : s3_idx_reg[0];
        for (int p = 0; p < NUM_PLANES; p++) begin
            acc_next[p] = {acc_reg[p][6:0], fin_idx[p]};
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (pipe_adv && s3_valid_reg && s3_last_reg) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state and palette
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < PALETTE_ENTRIES; i++) begin
                palette_reg[i] <= '0;
            end
        end else begin
            m_valid_reg <= m_valid_next;
            if (pipe_adv) begin
                s1_valid_reg <= issue;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
            end
            if (s_accept && (s_data.func == FUNC_CONVERT)) begin
                cnt_reg <= CNT_W'(GROUP_PIXELS);
            end else if (issue && pipe_adv) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            if (s_accept && (s_data.func == FUNC_PAL_WRITE)) begin
                for (int i = 0; i < PALETTE_ENTRIES; i++) begin
                    if (s_data.pal_index == IDX_W'(i)) begin
                        palette_reg[i] <= s_data.pal_color;
                    end
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (s_accept && (s_data.func == FUNC_CONVERT)) begin
            pix_sh_reg[0] <= s_data.pixel0;
            pix_sh_reg[1] <= s_data.pixel1;
            pix_sh_reg[2] <= s_data.pixel2;
            pix_sh_reg[3] <= s_data.pixel3;
            pix_sh_reg[4] <= s_data.pixel4;
            pix_sh_reg[5] <= s_data.pixel5;
            pix_sh_reg[6] <= s_data.pixel6;
            pix_sh_reg[7] <= s_data.pixel7;
        end else if (issue && pipe_adv) begin
            for (int k = 0; k < GROUP_PIXELS - 1; k++) begin
                pix_sh_reg[k] <= pix_sh_reg[k+1];
            end
        end
        if (pipe_adv) begin
            s1_last_reg <= cnt_reg == CNT_W'(1);
            s2_last_reg <= s1_last_reg;
            s3_last_reg <= s2_last_reg;
            s1_dist_reg <= lane_dist;
            s2_dist_reg <= s2_dist_next;
            s2_idx_reg  <= s2_idx_next;
            s3_dist_reg <= s3_dist_next;
            s3_idx_reg  <= s3_idx_next;
            if (s3_valid_reg) begin
                acc_reg <= acc_next;
                if (s3_last_reg) begin
                    m_data_reg.plane0 <= acc_next[0];
                    m_data_reg.plane1 <= acc_next[1];
                    m_data_reg.plane2 <= acc_next[2];
                    m_data_reg.plane3 <= acc_next[3];
                    m_data_reg.plane4 <= acc_next[4];
                end
            end
        end
    end

    `RPQB_ASSERT_IMPLY(a_busy_blocks_input, cnt_reg > CNT_W'(1), !s_ready, "input taken mid group")
    `RPQB_ASSERT_NEXT(a_group_loads, s_accept && (s_data.func == FUNC_CONVERT), cnt_reg == CNT_W'(GROUP_PIXELS), "group word did not load")
    `RPQB_ASSERT_NEXT(a_stall_holds, !pipe_adv, $stable(s3_valid_reg) && $stable(fin_idx), "stalled tail changed")
    `RPQB_ASSERT_NEXT(a_last_delivers, pipe_adv && s3_valid_reg && s3_last_reg, m_valid_reg, "finished word lost")

endmodule
